// ----- rtl/core/ffgp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffgp_pkg
// Shared constants, register codes and result type of the rectangle placer.
// ----------------------------------------------------------------------------
package ffgp_pkg;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  localparam int SIZE_W     = 7;
  localparam int COORD_W    = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_STRIP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_LENGTH = 1'b1;

  localparam logic [SIZE_W-1:0] STRIP_RESET = 7'd64;

  typedef struct packed {
    logic               placed;
    logic [COORD_W-1:0] left_col;
    logic [COORD_W-1:0] top_row;
    logic [COORD_W-1:0] right_col;
    logic [COORD_W-1:0] bottom_row;
  } res_t;

endpackage

// ----- rtl/core/ffgp_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffgp_req_if
// Request channel: one rectangle request per transfer.
// ----------------------------------------------------------------------------
interface ffgp_req_if;
  logic                        valid;
  logic                        ready;
  logic                        restart;
  logic [ffgp_pkg::SIZE_W-1:0] rect_width;
  logic [ffgp_pkg::SIZE_W-1:0] rect_height;

  modport source (output valid, restart, rect_width, rect_height, input ready);
  modport sink   (input valid, restart, rect_width, rect_height, output ready);
endinterface

// ----- rtl/core/ffgp_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffgp_res_if
// Result channel: placement outcome and corners per transfer.
// ----------------------------------------------------------------------------
interface ffgp_res_if;
  logic                         valid;
  logic                         ready;
  logic                         placed;
  logic [ffgp_pkg::COORD_W-1:0] left_col;
  logic [ffgp_pkg::COORD_W-1:0] top_row;
  logic [ffgp_pkg::COORD_W-1:0] right_col;
  logic [ffgp_pkg::COORD_W-1:0] bottom_row;

  modport source (output valid, placed, left_col, top_row, right_col, bottom_row,
                  input ready);
  modport sink   (input valid, placed, left_col, top_row, right_col, bottom_row,
                  output ready);
endinterface

// ----- rtl/core/ffgp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffgp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffgp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/ffgp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffgp_ctrl
// Placement engine: clears, scans and marks the occupancy rows in memory.
// ----------------------------------------------------------------------------
module ffgp_ctrl #(
  parameter int MAX_COLUMNS = ffgp_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = ffgp_pkg::DEF_MAX_ROWS,
  localparam int CW = ($clog2(MAX_COLUMNS + 1) > ffgp_pkg::SIZE_W) ?
                      $clog2(MAX_COLUMNS + 1) : ffgp_pkg::SIZE_W,
  localparam int RW = ($clog2(MAX_ROWS + 1) > ffgp_pkg::SIZE_W) ?
                      $clog2(MAX_ROWS + 1) : ffgp_pkg::SIZE_W,
  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic                        restart,
  input  logic [ffgp_pkg::SIZE_W-1:0] rect_width,
  input  logic [ffgp_pkg::SIZE_W-1:0] rect_height,
  input  logic [CW-1:0]               sw,
  input  logic [RW-1:0]               sl,
  output logic                        done_valid,
  input  logic                        done_ready,
  output ffgp_pkg::res_t              done_res,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [MAX_COLUMNS-1:0]      rd_data,
  output logic                        we,
  output logic [AW-1:0]               wr_addr,
  output logic [MAX_COLUMNS-1:0]      wr_data
);

  typedef enum logic [2:0] {
    CLEAR, IDLE, CHECK, ROWACC, COLSCAN, MARK_RD, MARK_WR, DONE
  } state_t;

  localparam logic [MAX_COLUMNS-1:0] ONES = {MAX_COLUMNS{1'b1}};

  state_t                 state;
  logic                   held;
  logic [CW-1:0]          w;
  logic [RW-1:0]          h;
  logic [RW-1:0]          row;
  logic [RW-1:0]          idx;
  logic                   pend;
  logic [MAX_COLUMNS-1:0] acc;
  logic [MAX_COLUMNS-1:0] scan;
  logic [MAX_COLUMNS-1:0] wmask;
  logic [MAX_COLUMNS-1:0] mask;
  logic [CW-1:0]          col;
  logic [CW-1:0]          run;
  logic [CW-1:0]          left;
  ffgp_pkg::res_t         result;

  logic [RW-1:0] row_idx;
  logic [CW-1:0] run_next;
  logic [CW-1:0] left_next;
  logic [CW-1:0] right_c;
  logic [RW-1:0] bottom_r;

  assign row_idx   = row + idx;
  assign run_next  = scan[0] ? '0 : run + CW'(1);
  assign left_next = col + CW'(1) - w;
  assign right_c   = left + w - CW'(1);
  assign bottom_r  = row + h - RW'(1);

  assign req_ready  = (state == IDLE);
  assign done_valid = (state == DONE);
  assign done_res   = result;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = row_idx[AW-1:0];
    we      = 1'b0;
    wr_addr = row_idx[AW-1:0];
    wr_data = rd_data | mask;
    case (state)
      CLEAR: begin
        we      = 1'b1;
        wr_addr = idx[AW-1:0];
        wr_data = '0;
      end
      ROWACC:  rd_en = (idx < h);
      MARK_RD: rd_en = 1'b1;
      MARK_WR: we    = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
      idx   <= '0;
      held  <= 1'b0;
    end else begin
      unique case (state)
        CLEAR: begin
          if (idx == RW'(MAX_ROWS - 1)) begin
            idx   <= '0;
            state <= held ? CHECK : IDLE;
          end else begin
            idx <= idx + RW'(1);
          end
        end
        IDLE: begin
          if (req_valid) begin
            w     <= CW'(rect_width);
            h     <= RW'(rect_height);
            held  <= 1'b1;
            idx   <= '0;
            state <= restart ? CLEAR : CHECK;
          end
        end
        CHECK: begin
          wmask <= ONES >> (CW'(MAX_COLUMNS) - w);
          if (w == '0 || h == '0 || w > sw || h > sl) begin
            result <= '0;
            state  <= DONE;
          end else begin
            row   <= '0;
            idx   <= '0;
            pend  <= 1'b0;
            acc   <= '0;
            state <= ROWACC;
          end
        end
        ROWACC: begin
          if (idx < h) begin
            idx <= idx + RW'(1);
          end
          pend <= (idx < h);
          if (pend) begin
            if (idx == h) begin
              scan  <= acc | rd_data;
              col   <= '0;
              run   <= '0;
              state <= COLSCAN;
            end else begin
              acc <= acc | rd_data;
            end
          end
        end
        COLSCAN: begin
          if (run_next == w) begin
            left  <= left_next;
            mask  <= wmask << left_next;
            idx   <= '0;
            state <= MARK_RD;
          end else if (col + CW'(1) == sw) begin
            if (row + h >= sl) begin
              result <= '0;
              state  <= DONE;
            end else begin
              row   <= row + RW'(1);
              idx   <= '0;
              pend  <= 1'b0;
              acc   <= '0;
              state <= ROWACC;
            end
          end else begin
            col  <= col + CW'(1);
            run  <= run_next;
            scan <= scan >> 1;
          end
        end
        MARK_RD: state <= MARK_WR;
        MARK_WR: begin
          if (idx + RW'(1) == h) begin
            result.placed     <= 1'b1;
            result.left_col   <= left[ffgp_pkg::COORD_W-1:0];
            result.top_row    <= row[ffgp_pkg::COORD_W-1:0];
            result.right_col  <= right_c[ffgp_pkg::COORD_W-1:0];
            result.bottom_row <= bottom_r[ffgp_pkg::COORD_W-1:0];
            state             <= DONE;
          end else begin
            idx   <= idx + RW'(1);
            state <= MARK_RD;
          end
        end
        DONE: begin
          if (done_ready) begin
            held  <= 1'b0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && we && rd_addr == wr_addr))
    else $error("read and write hit the same row in one cycle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state != IDLE))
    else $error("accepted request did not start work");

  a_rowacc_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ROWACC) |-> (idx <= h))
    else $error("row accumulation read past the footprint");

  a_rowacc_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ROWACC) |-> (w != '0 && h != '0))
    else $error("zero-sized rectangle entered the scan");
`endif

endmodule

// ----- rtl/core/first_fit_grid_rectangle_placer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_grid_rectangle_placer
// First-fit placement of rectangles on an occupancy grid held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req: one rectangle (restart, rect_width, rect_height) per transfer.
//   res: one result (placed and corners) per request, in order.
//   cfg: cfg_we/cfg_idx/cfg_data write strip_width (0) or strip_length (1);
//        write only while no request is in flight.
// Steps per request: setup, then for each candidate top row a pass of row
//   reads (one RAM read port, one row a cycle) and a column scan of up to
//   strip_width columns, then read-modify-write marking of the footprint
//   rows, and the move into the result register. A restart adds a clearing
//   pass first.
// Reset: a clearing pass zeroes the grid; req.ready stays low until it
//   ends. Registers reset to 64.
// Stall: the result register holds a finished result while res.ready is low;
//   the next request is accepted and worked on meanwhile, and the engine
//   waits only when its own result finds the register still full.
// ----------------------------------------------------------------------------
module first_fit_grid_rectangle_placer #(
  parameter int MAX_COLUMNS = ffgp_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = ffgp_pkg::DEF_MAX_ROWS
) (
  input  logic                            clk,
  input  logic                            rst,
  ffgp_req_if.sink                        req,
  ffgp_res_if.source                      res,
  input  logic                            cfg_we,
  input  logic [ffgp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ffgp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = ($clog2(MAX_COLUMNS + 1) > ffgp_pkg::SIZE_W) ?
                      $clog2(MAX_COLUMNS + 1) : ffgp_pkg::SIZE_W;
  localparam int RW = ($clog2(MAX_ROWS + 1) > ffgp_pkg::SIZE_W) ?
                      $clog2(MAX_ROWS + 1) : ffgp_pkg::SIZE_W;
  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [ffgp_pkg::SIZE_W-1:0] strip_width;
  logic [ffgp_pkg::SIZE_W-1:0] strip_length;
  logic [CW-1:0]               sw;
  logic [RW-1:0]               sl;

  logic                        done_valid;
  logic                        done_ready;
  ffgp_pkg::res_t              done_res;
  logic                        out_valid;
  ffgp_pkg::res_t              out_res;

  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [MAX_COLUMNS-1:0]      rd_data;
  logic                        we;
  logic [AW-1:0]               wr_addr;
  logic [MAX_COLUMNS-1:0]      wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_width  <= ffgp_pkg::STRIP_RESET;
      strip_length <= ffgp_pkg::STRIP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ffgp_pkg::REG_STRIP_WIDTH:  strip_width  <= cfg_data;
        ffgp_pkg::REG_STRIP_LENGTH: strip_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sw = (CW'(strip_width) > CW'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : CW'(strip_width);
  assign sl = (RW'(strip_length) > RW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(strip_length);

  assign done_ready = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_valid && done_ready) begin
      out_valid <= 1'b1;
      out_res   <= done_res;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res.valid      = out_valid;
  assign res.placed     = out_res.placed;
  assign res.left_col   = out_res.left_col;
  assign res.top_row    = out_res.top_row;
  assign res.right_col  = out_res.right_col;
  assign res.bottom_row = out_res.bottom_row;

  ffgp_ctrl #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .restart     (req.restart),
    .rect_width  (req.rect_width),
    .rect_height (req.rect_height),
    .sw          (sw),
    .sl          (sl),
    .done_valid  (done_valid),
    .done_ready  (done_ready),
    .done_res    (done_res),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .we          (we),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  ffgp_ram #(
    .WIDTH (MAX_COLUMNS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the rectangle placer against a grid model kept in the bench. Each
// rectangle request is predicted at its transfer and each result is compared
// field by field, in order. The run covers several strip sizes, including
// empty and oversized strips. The sender works in bursts, and the receiver
// stalls on a pattern that includes long hold-offs.
// ----------------------------------------------------------------------------
module testbench;

  localparam int GRID_COLS = ffgp_pkg::DEF_MAX_COLUMNS;
  localparam int GRID_ROWS = ffgp_pkg::DEF_MAX_ROWS;

  typedef struct packed {
    logic                        restart;
    logic [ffgp_pkg::SIZE_W-1:0] rect_width;
    logic [ffgp_pkg::SIZE_W-1:0] rect_height;
  } rect_req_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we;
  logic [ffgp_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [ffgp_pkg::CFG_DATA_W-1:0] cfg_data;

  ffgp_req_if req ();
  ffgp_res_if res ();

  first_fit_grid_rectangle_placer DUT (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bench copy of the grid and of the strip registers
  logic [GRID_COLS-1:0]        occupancy [GRID_ROWS];
  logic [ffgp_pkg::SIZE_W-1:0] strip_w;
  logic [ffgp_pkg::SIZE_W-1:0] strip_l;

  rect_req_t        rect_requests [$];
  ffgp_pkg::res_t   expected_placements [$];
  int unsigned      requests_sent = 0;
  int unsigned      placements_seen = 0;
  int unsigned      failures = 0;

  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_mode;
  int unsigned stall_left;
  int unsigned hold_cycles;
  int unsigned transfers_in;
  logic [1:0]  holds_fired;

  function automatic ffgp_pkg::res_t place_rect(logic restart,
                                                logic [ffgp_pkg::SIZE_W-1:0] w,
                                                logic [ffgp_pkg::SIZE_W-1:0] h);
    ffgp_pkg::res_t       r;
    int                   sw;
    int                   sl;
    logic [GRID_COLS-1:0] span;
    logic                 clash;
    r = '0;
    sw = (strip_w > GRID_COLS) ? GRID_COLS : strip_w;
    sl = (strip_l > GRID_ROWS) ? GRID_ROWS : strip_l;
    if (restart) begin
      foreach (occupancy[i]) occupancy[i] = '0;
    end
    if (w == 0 || h == 0 || w > sw || h > sl) return r;
    for (int row = 0; row + h <= sl; row++) begin
      for (int col = 0; col + w <= sw; col++) begin
        span = ({GRID_COLS{1'b1}} >> (GRID_COLS - w)) << col;
        clash = 1'b0;
        for (int k = row; k < row + h; k++) clash |= |(occupancy[k] & span);
        if (!clash) begin
          for (int k = row; k < row + h; k++) occupancy[k] |= span;
          r.placed     = 1'b1;
          r.left_col   = ffgp_pkg::COORD_W'(col);
          r.top_row    = ffgp_pkg::COORD_W'(row);
          r.right_col  = ffgp_pkg::COORD_W'(col + w - 1);
          r.bottom_row = ffgp_pkg::COORD_W'(row + h - 1);
          return r;
        end
      end
    end
    return r;
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid       <= 1'b0;
      req.restart     <= 1'b0;
      req.rect_width  <= '0;
      req.rect_height <= '0;
      burst_left = 1;
      gap_left   = 0;
      foreach (occupancy[i]) occupancy[i] = '0;
    end else begin
      if (req.valid && req.ready) begin
        expected_placements.insert(expected_placements.size(),
                                   place_rect(req.restart, req.rect_width,
                                              req.rect_height));
      end
      if (!req.valid || req.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          req.valid <= 1'b0;
        end else if (rect_requests.size() != 0) begin
          rect_req_t item;
          item = rect_requests.pop_front();
          req.valid       <= 1'b1;
          req.restart     <= item.restart;
          req.rect_width  <= item.rect_width;
          req.rect_height <= item.rect_height;
          requests_sent++;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-offs once the run is under way
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles  <= 0;
      transfers_in <= 0;
      holds_fired  <= '0;
    end else begin
      if (req.valid && req.ready) transfers_in <= transfers_in + 1;
      if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
      end else if (!holds_fired[0] && transfers_in >= 150) begin
        hold_cycles    <= 3000;
        holds_fired[0] <= 1'b1;
      end else if (!holds_fired[1] && transfers_in >= 650) begin
        hold_cycles    <= 3000;
        holds_fired[1] <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
    end else begin
      if (res.valid && res.ready) begin
        ffgp_pkg::res_t want;
        placements_seen++;
        if (expected_placements.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result: placed=%0b l=%0d t=%0d r=%0d b=%0d",
                     res.placed, res.left_col, res.top_row, res.right_col,
                     res.bottom_row);
        end else begin
          want = expected_placements.pop_front();
          if (res.placed !== want.placed || res.left_col !== want.left_col ||
              res.top_row !== want.top_row || res.right_col !== want.right_col ||
              res.bottom_row !== want.bottom_row) begin
            failures++;
            if (failures <= 10)
              $display("result %0d mismatch: exp placed=%0b l=%0d t=%0d r=%0d b=%0d %s",
                       placements_seen, want.placed, want.left_col, want.top_row,
                       want.right_col, want.bottom_row,
                       $sformatf("got placed=%0b l=%0d t=%0d r=%0d b=%0d",
                                 res.placed, res.left_col, res.top_row,
                                 res.right_col, res.bottom_row));
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(50, 400);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: res.ready <= (hold_cycles == 0);
        1: res.ready <= (hold_cycles == 0) && ($urandom_range(0, 1) == 0);
        2: res.ready <= (hold_cycles == 0) && ($urandom_range(0, 3) == 0);
        default: res.ready <= (hold_cycles == 0) && ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  task automatic add_rect(logic restart, logic [ffgp_pkg::SIZE_W-1:0] w,
                          logic [ffgp_pkg::SIZE_W-1:0] h);
    rect_req_t item;
    item.restart     = restart;
    item.rect_width  = w;
    item.rect_height = h;
    rect_requests.insert(rect_requests.size(), item);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (rect_requests.size() != 0 || requests_sent != placements_seen);
  endtask

  task automatic write_strip(logic [ffgp_pkg::CFG_IDX_W-1:0] idx,
                             logic [ffgp_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == ffgp_pkg::REG_STRIP_WIDTH) strip_w = val;
    else strip_l = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [ffgp_pkg::CFG_DATA_W-1:0] w_cfg,
                           logic [ffgp_pkg::CFG_DATA_W-1:0] l_cfg, int n);
    int                          sw;
    int                          sl;
    logic [ffgp_pkg::SIZE_W-1:0] w;
    logic [ffgp_pkg::SIZE_W-1:0] h;
    write_strip(ffgp_pkg::REG_STRIP_WIDTH, w_cfg);
    write_strip(ffgp_pkg::REG_STRIP_LENGTH, l_cfg);
    sw = (strip_w > GRID_COLS) ? GRID_COLS : strip_w;
    sl = (strip_l > GRID_ROWS) ? GRID_ROWS : strip_l;
    repeat (n) begin
      if (sw == 0 || sl == 0 || $urandom_range(0, 99) < 15) begin
        w = ffgp_pkg::SIZE_W'($urandom_range(0, 127));
        h = ffgp_pkg::SIZE_W'($urandom_range(0, 127));
      end else begin
        w = ffgp_pkg::SIZE_W'($urandom_range(0, 1) ? $urandom_range(1, (sw + 3) / 4)
                                                   : $urandom_range(1, sw));
        h = ffgp_pkg::SIZE_W'($urandom_range(0, 1) ? $urandom_range(1, (sl + 3) / 4)
                                                   : $urandom_range(1, sl));
      end
      add_rect($urandom_range(0, 11) == 0, w, h);
    end
    drain();
  endtask

  initial begin
    cfg_we          = 1'b0;
    cfg_idx         = ffgp_pkg::REG_STRIP_WIDTH;
    cfg_data        = '0;
    strip_w         = ffgp_pkg::STRIP_RESET;
    strip_l         = ffgp_pkg::STRIP_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // full strip, then fill-up, zero and oversized sizes, restart
    add_rect(1'b0, 64, 64);
    add_rect(1'b0, 1, 1);
    add_rect(1'b1, 1, 1);
    add_rect(1'b0, 0, 5);
    add_rect(1'b0, 5, 0);
    add_rect(1'b0, 0, 0);
    add_rect(1'b0, 65, 1);
    add_rect(1'b0, 1, 65);
    add_rect(1'b0, 127, 127);
    add_rect(1'b0, 63, 1);
    add_rect(1'b0, 1, 64);
    add_rect(1'b0, 2, 2);
    add_rect(1'b1, 64, 1);
    add_rect(1'b0, 64, 63);
    add_rect(1'b0, 1, 1);
    add_rect(1'b1, 32, 32);
    add_rect(1'b0, 32, 32);
    add_rect(1'b0, 32, 32);
    add_rect(1'b0, 32, 32);
    add_rect(1'b0, 32, 32);
    drain();

    // shrink the strip over a full grid, then empty and oversized strips
    run_phase(8, 8, 10);
    run_phase(0, 0, 10);
    run_phase(0, 20, 10);
    run_phase(20, 0, 10);
    run_phase(127, 100, 60);
    run_phase(64, 64, 60);
    run_phase(1, 1, 40);
    run_phase(64, 1, 50);
    run_phase(1, 64, 50);
    repeat (8) run_phase(ffgp_pkg::CFG_DATA_W'($urandom_range(1, 16)),
                         ffgp_pkg::CFG_DATA_W'($urandom_range(1, 16)), 95);

    repeat (300) @(posedge clk);
    if (failures == 0 && expected_placements.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
